// ----- design/line_offset_table_lookup_top_assert.svh -----
// Assertion macros used by the checker file of the line offset table.
`ifndef LINE_OFFSET_TABLE_LOOKUP_TOP_ASSERT_SVH
`define LINE_OFFSET_TABLE_LOOKUP_TOP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define LOTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LOTL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/lotl_pkg.sv -----
// ----------------------------------------------------------------------------
// lotl_pkg
// Types and codes shared by the line offset table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package lotl_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOT_INCR = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] byte_offset;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] line_number;
    logic [31:0]        column_number;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic room;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } lotl_state_t;

endpackage

`default_nettype wire

// ----- design/lotl_core.sv -----
// ----------------------------------------------------------------------------
// lotl_core
// Line start table memory with the command sequencer and binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module lotl_core import lotl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  core_ctl_t          ctl,
  input  in_word_t           in_word,
  input  logic signed [31:0] first_line_number,
  output core_stat_t         stat,
  output out_word_t          res_word
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 1;

  function automatic logic [IW-1:0] mid_of(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [CW-1:0] span;
    begin
      span = {1'b0, b} - {1'b0, a} + CW'(1);
      mid_of = a + span[CW-1:1];
    end
  endfunction

  lotl_state_t state, state_next;

  logic [31:0]   mem [TABLE_DEPTH];
  logic [31:0]   rdata;
  logic          rd_en;
  logic [IW-1:0] raddr;
  logic          we;

  logic [CW-1:0] count, count_next;
  logic [31:0]   last_start, last_start_next;
  logic [IW-1:0] lo, lo_next;
  logic [IW-1:0] hi, hi_next;
  logic [IW-1:0] mid, mid_next;
  logic [31:0]   lo_start, lo_start_next;
  logic [31:0]   pos, pos_next;
  out_word_t     res_next;

  logic [CW-1:0] count_m1;
  logic [IW-1:0] top_index;
  logic          step_le;
  logic [IW-1:0] step_lo;
  logic [IW-1:0] step_hi;
  logic [31:0]   step_start;
  logic          step_more;

  assign count_m1   = count - CW'(1);
  assign top_index  = count_m1[IW-1:0];
  assign step_le    = rdata <= pos;
  assign step_lo    = step_le ? mid : lo;
  assign step_hi    = step_le ? hi : mid - IW'(1);
  assign step_start = step_le ? rdata : lo_start;
  assign step_more  = step_lo < step_hi;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[IW-1:0]] <= pos_next;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= CW'(1);
      last_start <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      last_start <= last_start_next;
    end
  end

  always_ff @(posedge clk) begin
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    lo_start <= lo_start_next;
    pos      <= pos_next;
    res_word <= res_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.start) begin
          if (in_word.cmd == CMD_LOOKUP && top_index != '0) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SEARCH: begin
        if (!step_more) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (ctl.room) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next      = count;
    last_start_next = last_start;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    lo_start_next   = lo_start;
    pos_next        = pos;
    res_next        = res_word;
    we              = 1'b0;
    rd_en           = 1'b0;
    raddr           = mid;
    stat.busy       = state != S_IDLE;
    stat.done       = state == S_DONE && ctl.room;
    unique case (state)
      S_IDLE: begin
        if (ctl.start) begin
          pos_next = in_word.byte_offset;
          res_next = '0;
          unique case (in_word.cmd)
            CMD_APPEND: begin
              if (count >= CW'(TABLE_DEPTH)) begin
                res_next.status = STATUS_FULL;
              end else if (in_word.byte_offset <= last_start) begin
                res_next.status = STATUS_NOT_INCR;
              end else begin
                we              = 1'b1;
                count_next      = count + CW'(1);
                last_start_next = in_word.byte_offset;
              end
            end
            CMD_CLEAR: begin
              count_next      = CW'(1);
              last_start_next = '0;
            end
            CMD_LOOKUP: begin
              lo_next       = '0;
              hi_next       = top_index;
              lo_start_next = '0;
              if (top_index != '0) begin
                mid_next = mid_of('0, top_index);
                raddr    = mid_next;
                rd_en    = 1'b1;
              end else begin
                res_next.line_number   = first_line_number;
                res_next.column_number = in_word.byte_offset;
              end
            end
            default: res_next = '0;
          endcase
        end
      end
      S_SEARCH: begin
        lo_next       = step_lo;
        hi_next       = step_hi;
        lo_start_next = step_start;
        if (step_more) begin
          mid_next = mid_of(step_lo, step_hi);
          raddr    = mid_next;
          rd_en    = 1'b1;
        end else begin
          res_next.line_number   = first_line_number + 32'(step_lo);
          res_next.column_number = pos - step_start;
          res_next.status        = STATUS_OK;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/line_offset_table_lookup_top.sv -----
// ----------------------------------------------------------------------------
// line_offset_table_lookup_top
// Sorted line start table with append, clear and binary-search lookup.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | in_word: cmd, byte_offset
//  out      | out_valid / out_stall| out_word: line_number, column_number, status
//  config   | APB write / read     | first_line_number at byte address 0
//
//  Append, clear and the unused command go from accept straight to the done state.
//  A lookup runs a binary search with one memory read per search step before
//  it reaches the done state.
//  Reset needs no clearing pass: entry zero is held as a constant, not stored.
//  in_stall is high while a word is in work; a waiting result is held in the
//  output register and the block finishes the next word behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module line_offset_table_lookup_top import lotl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_FLN_ADDR = 2'd0;

  logic signed [31:0] first_line_number;
  core_ctl_t          ctl;
  core_stat_t         stat;
  out_word_t          res_word;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_FLN_ADDR) ? first_line_number : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_line_number <= 32'sd1;
    end else if (psel && penable && pwrite && pready && paddr == REG_FLN_ADDR) begin
      first_line_number <= pwdata;
    end
  end

  assign in_stall  = stat.busy;
  assign ctl.start = in_valid && !in_stall;
  assign ctl.room  = !out_valid || !out_stall;

  lotl_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .in_word          (in_word),
    .first_line_number(first_line_number),
    .stat             (stat),
    .res_word         (res_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_word <= res_word;
    end
  end

endmodule

`default_nettype wire

// ----- design/lotl_checker.sv -----
// ----------------------------------------------------------------------------
// lotl_checker
// Port-level checks of the line offset table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_offset_table_lookup_top_assert.svh"

module lotl_checker import lotl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_word_t   out_word
);

  `LOTL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted word did not make the block busy")
  `LOTL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")
  `LOTL_ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall), "result appeared without a word in work")

endmodule

bind line_offset_table_lookup_top lotl_checker u_lotl_checker (.*);

`default_nettype wire
